// ===== design/swmf_pkg.sv =====
// swmf_pkg: shared types, step numbers and the control store of the
// sliding window filter sequencer. no dependencies.
`timescale 1ns / 1ps

package swmf_pkg;

  localparam int unsigned PC_W       = 4;
  localparam int unsigned CH_FIELD_W = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned WSIZE_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;

  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd10;

  // step numbers of the control program
  localparam logic [PC_W-1:0] S_IDLE   = 4'd0;
  localparam logic [PC_W-1:0] S_UPDATE = 4'd1;
  localparam logic [PC_W-1:0] S_LOAD   = 4'd2;
  localparam logic [PC_W-1:0] S_LAST   = 4'd3;
  localparam logic [PC_W-1:0] S_SORT   = 4'd4;
  localparam logic [PC_W-1:0] S_HALF   = 4'd5;
  localparam logic [PC_W-1:0] S_SHIFT  = 4'd6;
  localparam logic [PC_W-1:0] S_MED    = 4'd7;
  localparam logic [PC_W-1:0] S_DIVI   = 4'd8;
  localparam logic [PC_W-1:0] S_DIV    = 4'd9;
  localparam logic [PC_W-1:0] S_MEAN   = 4'd10;
  localparam logic [PC_W-1:0] S_OUT    = 4'd11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_UPDATE,
    OP_LOAD,
    OP_SORT,
    OP_SHIFT,
    OP_MED,
    OP_DIV_INIT,
    OP_DIV,
    OP_MEAN,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IN_XFER,
    C_SKIP,
    C_MEAN,
    C_LOOP_W,
    C_HALF_ZERO,
    C_LOOP_HALF,
    C_LOOP_DIV,
    C_OUT_FREE
  } cond_e;

  typedef enum logic {
    SEQ_NEXT,
    SEQ_HOLD
  } seq_e;

  typedef struct packed {
    op_e             op;
    logic            cnt_clr;
    logic            cnt_inc;
    cond_e           cond;
    seq_e            seq;
    logic [PC_W-1:0] target;
  } ctl_t;

  // datapath status that the jump conditions test
  typedef struct packed {
    logic in_xfer;
    logic skip;
    logic mean;
    logic loop_w;
    logic half_zero;
    logic loop_half;
    logic loop_div;
    logic out_free;
  } flags_t;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{op: OP_NONE, cnt_clr: 1'b0, cnt_inc: 1'b0, cond: C_ALWAYS,
          seq: SEQ_NEXT, target: S_IDLE};
    unique case (pc)
      S_IDLE: begin
        w.op = OP_CAPTURE; w.cond = C_IN_XFER; w.seq = SEQ_HOLD; w.target = S_UPDATE;
      end
      S_UPDATE: begin
        w.op = OP_UPDATE; w.cnt_clr = 1'b1; w.cond = C_SKIP; w.target = S_OUT;
      end
      S_LOAD: begin
        w.op = OP_LOAD; w.cnt_inc = 1'b1; w.cond = C_LOOP_W; w.target = S_LOAD;
      end
      S_LAST: begin
        w.cnt_clr = 1'b1; w.cond = C_MEAN; w.target = S_DIVI;
      end
      S_SORT: begin
        w.op = OP_SORT; w.cnt_inc = 1'b1; w.cond = C_LOOP_W; w.target = S_SORT;
      end
      S_HALF: begin
        w.cnt_clr = 1'b1; w.cond = C_HALF_ZERO; w.target = S_MED;
      end
      S_SHIFT: begin
        w.op = OP_SHIFT; w.cnt_inc = 1'b1; w.cond = C_LOOP_HALF; w.target = S_SHIFT;
      end
      S_MED: begin
        w.op = OP_MED; w.cond = C_ALWAYS; w.target = S_OUT;
      end
      S_DIVI: begin
        w.op = OP_DIV_INIT; w.cnt_clr = 1'b1; w.cond = C_NONE;
      end
      S_DIV: begin
        w.op = OP_DIV; w.cnt_inc = 1'b1; w.cond = C_LOOP_DIV; w.target = S_DIV;
      end
      S_MEAN: begin
        w.op = OP_MEAN; w.cond = C_NONE;
      end
      S_OUT: begin
        w.op = OP_EMIT; w.cond = C_OUT_FREE; w.seq = SEQ_HOLD; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/sliding_window_median_mean_filter.sv =====
// sliding_window_median_mean_filter: per-channel median / mean window filter.
// result per mode (w = effective window size): window not full or pass mode: the
// sample itself; median: the window is loaded, sorted and read at position w/2;
// mean: the window sum divided by w in a bit-serial divider.
// one item at a time: a next input can be taken in the cycle after the result
// is loaded into the output register. reset clears fill counts and pointers.
`timescale 1ns / 1ps

module sliding_window_median_mean_filter #(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned MAX_WINDOW  = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [swmf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // sample
  input  logic [swmf_pkg::CH_FIELD_W-1:0]   s_axis_tuser,  // channel
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,  // value
  output logic                              m_axis_tuser   // window_full
);
  import swmf_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned DW    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned PW    = $clog2(MAX_WINDOW);
  localparam int unsigned WW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int unsigned CNT_W = $clog2(((SW > MAX_WINDOW) ? SW : MAX_WINDOW) + 1);

  function automatic logic [CHW-1:0] fold_ch(input logic [CH_FIELD_W-1:0] c);
    int v;
    v = int'(c);
    for (int k = 0; k < (1 << CH_FIELD_W); k++) begin
      if (v >= int'(CHANNELS)) v = v - int'(CHANNELS);
    end
    return CHW'(v);
  endfunction

  ctl_t   ctl;
  flags_t flags;

  // control state
  logic [MODE_W-1:0]  mode_q;
  logic [WSIZE_W-1:0] wsize_q;
  logic [WW-1:0]      fill_q [CHANNELS];
  logic [PW-1:0]      ptr_q  [CHANNELS];
  logic               rd_pend_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q;

  // payload
  logic [SB-1:0]      mem_q [CHANNELS][MAX_WINDOW];
  logic [SB-1:0]      rdata_q;
  logic [CHW-1:0]     ch_q;
  logic [SB-1:0]      smp_q;
  logic [PW-1:0]      pos_q, pos_d;
  logic [SB-1:0]      win_q [MAX_WINDOW];
  logic [SB-1:0]      win_d [MAX_WINDOW];
  logic               vld_q [MAX_WINDOW];
  logic               vld_d [MAX_WINDOW];
  logic [SW-1:0]      sum_q, sum_d;
  logic               full_q;
  logic [SB-1:0]      result_q, result_d;
  logic [WW-1:0]      rem_q, rem_d;
  logic [SW-1:0]      dvd_q, dvd_d;
  logic               neg_q, neg_d;
  logic [SB-1:0]      out_value_q;
  logic               out_full_q;

  logic [WW-1:0] w_eff, half, fill_new;
  logic [PW-1:0] ptr_new;
  logic          full_new, out_free, emit, in_xfer;
  logic [WW:0]   rem_sh;
  logic          qbit;

  swmf_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (ctl.op == OP_CAPTURE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = (ctl.op == OP_EMIT) && out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DW'(out_value_q);
  assign m_axis_tuser  = out_full_q;

  // window size zero acts as one, sizes above the store saturate
  always_comb begin
    if (wsize_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(wsize_q) > int'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(wsize_q);
    end
  end
  assign half = w_eff >> 1;

  assign fill_new = (int'(fill_q[ch_q]) < int'(MAX_WINDOW)) ? fill_q[ch_q] + WW'(1)
                                                           : fill_q[ch_q];
  assign full_new = (fill_new >= w_eff);
  assign ptr_new  = (int'(ptr_q[ch_q]) == int'(MAX_WINDOW) - 1) ? '0
                                                                : ptr_q[ch_q] + PW'(1);

  always_comb begin
    flags.in_xfer   = in_xfer;
    flags.skip      = !full_new || mode_q[1];
    flags.mean      = (mode_q == MODE_MEAN);
    flags.loop_w    = (int'(cnt_q) + 1 < int'(w_eff));
    flags.half_zero = (half == '0);
    flags.loop_half = (int'(cnt_q) + 1 < int'(half));
    flags.loop_div  = (int'(cnt_q) + 1 < int'(SW));
    flags.out_free  = out_free;
  end

  // restoring divider step: remainder stays below the window size
  assign rem_sh = {rem_q, dvd_q[SW-1]};
  assign qbit   = (rem_sh >= {1'b0, w_eff});

  always_comb begin
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    result_d = result_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    neg_d    = neg_q;
    for (int i = 0; i < int'(MAX_WINDOW); i++) begin
      win_d[i] = win_q[i];
      vld_d[i] = vld_q[i];
    end

    if (ctl.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end

    // registered read data lands in the window in the cycle after the read
    if (rd_pend_q) begin
      for (int i = int'(MAX_WINDOW) - 1; i > 0; i--) begin
        win_d[i] = win_q[i-1];
        vld_d[i] = vld_q[i-1];
      end
      win_d[0] = rdata_q;
      vld_d[0] = 1'b1;
      sum_d    = sum_q + {{(SW-SB){rdata_q[SB-1]}}, rdata_q};
    end

    unique case (ctl.op)
      OP_UPDATE: begin
        pos_d    = ptr_q[ch_q];
        sum_d    = '0;
        result_d = smp_q;
        for (int i = 0; i < int'(MAX_WINDOW); i++) vld_d[i] = 1'b0;
      end
      OP_LOAD: begin
        pos_d = (pos_q == '0) ? PW'(MAX_WINDOW - 1) : pos_q - PW'(1);
      end
      OP_SORT: begin
        // odd-even transposition pass, empty slots order after all samples
        for (int i = 0; i < int'(MAX_WINDOW) - 1; i++) begin
          if ((i % 2) == int'(cnt_q[0])) begin
            if ((!vld_q[i] && vld_q[i+1]) ||
                (vld_q[i] && vld_q[i+1] && ($signed(win_q[i]) > $signed(win_q[i+1])))) begin
              win_d[i]   = win_q[i+1];
              win_d[i+1] = win_q[i];
              vld_d[i]   = vld_q[i+1];
              vld_d[i+1] = vld_q[i];
            end
          end
        end
      end
      OP_SHIFT: begin
        for (int i = 0; i < int'(MAX_WINDOW) - 1; i++) begin
          win_d[i] = win_q[i+1];
          vld_d[i] = vld_q[i+1];
        end
      end
      OP_MED: begin
        result_d = win_q[0];
      end
      OP_DIV_INIT: begin
        neg_d = sum_q[SW-1];
        dvd_d = sum_q[SW-1] ? (~sum_q + SW'(1)) : sum_q;
        rem_d = '0;
      end
      OP_DIV: begin
        rem_d = qbit ? WW'(rem_sh - {1'b0, w_eff}) : WW'(rem_sh);
        dvd_d = {dvd_q[SW-2:0], qbit};
      end
      OP_MEAN: begin
        result_d = neg_q ? (~dvd_q[SB-1:0] + SB'(1)) : dvd_q[SB-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_MEDIAN;
      wsize_q     <= WSIZE_RESET;
      rd_pend_q   <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < int'(CHANNELS); c++) begin
        fill_q[c] <= '0;
        ptr_q[c]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FILTER_MODE) begin
          mode_q <= cfg_data_i[MODE_W-1:0];
        end else if (cfg_index_i == CFG_WINDOW_SIZE) begin
          wsize_q <= cfg_data_i[WSIZE_W-1:0];
        end
      end
      rd_pend_q <= (ctl.op == OP_LOAD);
      cnt_q     <= cnt_d;
      if (ctl.op == OP_UPDATE) begin
        fill_q[ch_q] <= fill_new;
        ptr_q[ch_q]  <= ptr_new;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q  <= fold_ch(s_axis_tuser);
      smp_q <= s_axis_tdata[SB-1:0];
    end
    if (ctl.op == OP_UPDATE) begin
      mem_q[ch_q][ptr_q[ch_q]] <= smp_q;
      full_q <= full_new;
    end
    if (ctl.op == OP_LOAD) begin
      rdata_q <= mem_q[ch_q][pos_q];
    end
    if (emit) begin
      out_value_q <= result_q;
      out_full_q  <= full_q;
    end
    pos_q    <= pos_d;
    sum_q    <= sum_d;
    result_q <= result_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    neg_q    <= neg_d;
    for (int i = 0; i < int'(MAX_WINDOW); i++) begin
      win_q[i] <= win_d[i];
      vld_q[i] <= vld_d[i];
    end
  end

  // no window read may still be in flight when a new sample is taken
  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rd_pend_q)
    else $error("window read pending while taking input");

  // the median is always picked from a loaded slot
  a_median_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == OP_MED) |-> vld_q[0])
    else $error("median taken from an empty slot");

  // fill count of the active channel never passes the store depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.op == OP_UPDATE) |-> (int'(fill_q[ch_q]) <= int'(MAX_WINDOW)))
    else $error("fill count above store depth");

  // a result loaded into the output register is presented next cycle
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

endmodule

// ===== design/swmf_seq.sv =====
// swmf_seq: step counter and control store of the filter sequencer.
// depends on swmf_pkg for the control word, the flags and the program.
`timescale 1ns / 1ps

module swmf_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swmf_pkg::flags_t flags_i,
  output swmf_pkg::ctl_t  ctl_o
);
  import swmf_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctl_t            ctl;
  logic            jump;

  assign ctl   = ucode(pc_q);
  assign ctl_o = ctl;

  always_comb begin
    unique case (ctl.cond)
      C_NONE:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_IN_XFER:   jump = flags_i.in_xfer;
      C_SKIP:      jump = flags_i.skip;
      C_MEAN:      jump = flags_i.mean;
      C_LOOP_W:    jump = flags_i.loop_w;
      C_HALF_ZERO: jump = flags_i.half_zero;
      C_LOOP_HALF: jump = flags_i.loop_half;
      C_LOOP_DIV:  jump = flags_i.loop_div;
      C_OUT_FREE:  jump = flags_i.out_free;
      default:     jump = 1'b1;
    endcase
    if (jump) begin
      pc_d = ctl.target;
    end else if (ctl.seq == SEQ_HOLD) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
